// ----- rtl/olv_pkg.sv -----
// ----------------------------------------------------------------------------
// olv_pkg: shared types and codes for the ordered value list
// Operation and status codes, cell actions and the command bundle that the
// control logic broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package olv_pkg;

  // Most results that one dump transaction emits
  localparam int MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // What every cell does at the next clock edge
  typedef enum logic [2:0] {
    ACT_HOLD   = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_ROTATE = 3'd4
  } act_e;

  typedef struct packed {
    logic cmp_en;
    act_e act;
  } cell_cmd_t;

endpackage

// ----- rtl/ordered_value_list_top.sv -----
// ----------------------------------------------------------------------------
// ordered_value_list_top: ordered list of signed values in a chain of cells
// Append, insert-before-target, delete-first-match and dump over a row of
// CAPACITY cells, each holding one list position.
// ----------------------------------------------------------------------------
// Append, insert and delete: in the accept cycle every cell compares its value
// with the key; in the apply step that follows, which waits while the output
// register is still occupied, the tail cell is written (append) or the chain
// shifts by one position (insert, delete) on success, and the single result
// transaction is written to the output register. A dump rotates the occupied
// cells one position per cycle, emitting the head each time and stalling only
// while an emitted head waits for the output register; only the first sixteen
// entries are emitted, the rotation still runs over all of them to restore
// the order. A new transaction is accepted whenever the block is idle, even
// while the last result still waits in the output register.
module ordered_value_list_top #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [1:0]  opcode_i,
  input  logic signed [31:0] target_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [1:0]  status_o,
  output logic signed [31:0] item_value_o,
  output logic               last_item_o
);

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int EMIT_MAX = (CAPACITY < olv_pkg::MAX_RESULTS) ? CAPACITY
                                                              : olv_pkg::MAX_RESULTS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_APPLY = 2'd1;
  localparam logic [1:0] S_DUMP  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] walk_q, walk_d;
  olv_pkg::op_e     op_q;
  logic signed [VALUE_WIDTH-1:0] data_q;

  logic               out_valid_q;
  logic [1:0]         status_q;
  logic signed [31:0] item_q;
  logic               last_q;

  logic               accept;
  logic               slot_free;
  logic               load;
  olv_pkg::status_e   res_status;
  logic signed [31:0] res_item;
  logic               res_last;
  olv_pkg::cell_cmd_t cmd;

  logic signed [VALUE_WIDTH-1:0] key;
  logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] hit, hit_dec, ge, ge_prev, occ, at_tail, last_occ;
  logic                found;
  logic [CNT_W-1:0]    emit_n, cnt_last;
  logic                emitting;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Pick the compare key and take it to the stored width
  assign key = (olv_pkg::op_e'(opcode_i) == olv_pkg::OP_INSERT) ?
               VALUE_WIDTH'(target_i) : VALUE_WIDTH'(value_i);

  // Mark every position at or after the first match with one subtract
  assign hit_dec = hit - CAPACITY'(1);
  assign ge      = ~(hit_dec & ~hit);
  assign found   = |hit;

  assign cnt_last = count_q - CNT_W'(1);
  assign emit_n   = (count_q < CNT_W'(EMIT_MAX)) ? count_q : CNT_W'(EMIT_MAX);
  assign emitting = (walk_q < emit_n);

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] prev_val, next_val;

    assign occ[i]      = (CNT_W'(i) < count_q);
    assign at_tail[i]  = (CNT_W'(i) == count_q);
    assign last_occ[i] = (CNT_W'(i) == cnt_last);

    if (i == 0) begin : g_head
      assign prev_val   = data_q;
      assign ge_prev[i] = 1'b0;
    end else begin : g_body
      assign prev_val   = cell_val[i-1];
      assign ge_prev[i] = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    olv_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .key_i      (key),
      .data_i     (data_q),
      .prev_i     (prev_val),
      .next_i     (next_val),
      .head_i     (cell_val[0]),
      .occupied_i (occ[i]),
      .at_tail_i  (at_tail[i]),
      .last_occ_i (last_occ[i]),
      .ge_i       (ge[i]),
      .ge_prev_i  (ge_prev[i]),
      .value_o    (cell_val[i]),
      .hit_o      (hit[i])
    );
  end

  // Sequence the operation and drive the cell command
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    walk_d     = walk_q;
    cmd.cmp_en = accept;
    cmd.act    = olv_pkg::ACT_HOLD;
    load       = 1'b0;
    res_status = olv_pkg::ST_OK;
    res_item   = '0;
    res_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          walk_d  = '0;
          state_d = ((olv_pkg::op_e'(opcode_i) == olv_pkg::OP_DUMP) && (count_q != '0)) ?
                    S_DUMP : S_APPLY;
        end
      end
      S_APPLY: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
          case (op_q)
            olv_pkg::OP_APPEND: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                res_status = olv_pkg::ST_FULL;
              end else begin
                cmd.act = olv_pkg::ACT_APPEND;
                count_d = count_q + CNT_W'(1);
              end
            end
            olv_pkg::OP_INSERT: begin
              if (count_q == '0) begin
                res_status = olv_pkg::ST_EMPTY;
              end else if (!found) begin
                res_status = olv_pkg::ST_NOTFOUND;
              end else if (count_q == CNT_W'(CAPACITY)) begin
                res_status = olv_pkg::ST_FULL;
              end else begin
                cmd.act = olv_pkg::ACT_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            olv_pkg::OP_DELETE: begin
              if (count_q == '0) begin
                res_status = olv_pkg::ST_EMPTY;
              end else if (!found) begin
                res_status = olv_pkg::ST_NOTFOUND;
              end else begin
                cmd.act = olv_pkg::ACT_DELETE;
                count_d = cnt_last;
              end
            end
            default: begin
              // dump of an empty list
              res_status = olv_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      S_DUMP: begin
        // rotate once per step, emit the head while under the limit
        if (!emitting || slot_free) begin
          cmd.act = olv_pkg::ACT_ROTATE;
          if (emitting) begin
            load     = 1'b1;
            res_item = 32'(cell_val[0]);
            res_last = (walk_q == (emit_n - CNT_W'(1)));
          end
          if (walk_q == cnt_last) begin
            state_d = S_IDLE;
          end else begin
            walk_d = walk_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      walk_q  <= walk_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the operation and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= olv_pkg::op_e'(opcode_i);
      data_q <= VALUE_WIDTH'(value_i);
    end
    if (load) begin
      status_q <= res_status;
      item_q   <= res_item;
      last_q   <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign item_value_o = item_q;
  assign last_item_o  = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted transaction did not start work");

  a_apply_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) && slot_free |=> out_valid_o && (state_q == S_IDLE))
    else $error("single result not delivered");

  a_count_only_in_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == S_APPLY))
    else $error("entry count changed outside apply step");

  a_dump_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (walk_q < count_q))
    else $error("dump walk past the occupied entries");
`endif

endmodule

// ----- rtl/olv_cell.sv -----
// ----------------------------------------------------------------------------
// olv_cell: one position of the ordered value list
// Holds one value and a match flag. Compares against the broadcast key and
// takes its new value from itself, a neighbor, the head or the new data.
// ----------------------------------------------------------------------------
module olv_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  olv_pkg::cell_cmd_t            cmd_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  logic signed [VALUE_WIDTH-1:0] data_i,
  input  logic signed [VALUE_WIDTH-1:0] prev_i,
  input  logic signed [VALUE_WIDTH-1:0] next_i,
  input  logic signed [VALUE_WIDTH-1:0] head_i,
  input  logic                          occupied_i,
  input  logic                          at_tail_i,
  input  logic                          last_occ_i,
  input  logic                          ge_i,
  input  logic                          ge_prev_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          hit_o
);

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic                          hit_q, hit_d;

  // Select the next value for this position
  always_comb begin
    value_d = value_q;
    case (cmd_i.act)
      olv_pkg::ACT_APPEND: begin
        if (at_tail_i) begin
          value_d = data_i;
        end
      end
      olv_pkg::ACT_INSERT: begin
        // shift toward the tail from the first match on, drop new data at it
        if (ge_i) begin
          value_d = ge_prev_i ? prev_i : data_i;
        end
      end
      olv_pkg::ACT_DELETE: begin
        // close the gap from the first match on
        if (ge_i) begin
          value_d = next_i;
        end
      end
      olv_pkg::ACT_ROTATE: begin
        // rotate the occupied part toward the head, head wraps to the tail
        if (occupied_i) begin
          value_d = last_occ_i ? head_i : next_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  // Capture the compare result when a transaction is taken
  always_comb begin
    hit_d = cmd_i.cmp_en ? (occupied_i && (value_q == key_i)) : hit_q;
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    hit_q   <= hit_d;
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

// ----- bench/ordered_value_list_top_tb.sv -----
// ----------------------------------------------------------------------------
// ordered_value_list_top_tb: self-checking bench for the ordered value list
// Drives append, insert-before, delete and dump transactions through the
// valid/ready input channel, predicts every result from a shadow copy of the
// list and checks each output transaction in order, under random idling on
// both channels.
// ----------------------------------------------------------------------------
module ordered_value_list_top_tb;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int QUIET_ITEMS = 40;
  localparam int RAND_ITEMS  = 294;

  typedef struct {
    olv_pkg::op_e       op;
    logic signed [31:0] target;
    logic signed [31:0] value;
    bit                 drain;
  } list_op_t;

  typedef struct {
    olv_pkg::status_e   status;
    logic signed [31:0] item_value;
    logic               last_item;
  } list_result_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic        [1:0]  opcode_i     = olv_pkg::OP_APPEND;
  logic signed [31:0] target_i     = '0;
  logic signed [31:0] value_i      = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic        [1:0]  status_o;
  logic signed [31:0] item_value_o;
  logic               last_item_o;

  list_op_t     op_queue[$];
  list_result_t pending_results[$];
  list_op_t     in_flight;

  // Shadow of the list contents
  logic [VALUE_WIDTH-1:0] list_entries [CAPACITY];
  int                     list_len = 0;

  int mismatch_count = 0;
  int send_gap       = 0;
  int stall_left     = 0;
  bit quiet_tail     = 1'b0;

  ordered_value_list_top #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .target_i     (target_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .item_value_o (item_value_o),
    .last_item_o  (last_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Narrow a 32-bit field to the stored width after sign extension
  function automatic logic [VALUE_WIDTH-1:0] to_stored(logic signed [31:0] raw);
    logic signed [63:0] wide;
    wide = raw;
    return wide[VALUE_WIDTH-1:0];
  endfunction

  // Widen a stored value with its sign, then cut to the output field
  function automatic logic signed [31:0] to_emitted(logic [VALUE_WIDTH-1:0] stored);
    logic signed [VALUE_WIDTH-1:0] sv;
    logic signed [63:0]            wide;
    sv   = stored;
    wide = sv;
    return wide[31:0];
  endfunction

  function automatic int find_first(logic [VALUE_WIDTH-1:0] key);
    for (int i = 0; i < list_len; i++) begin
      if (list_entries[i] == key) return i;
    end
    return list_len;
  endfunction

  task automatic push_single(olv_pkg::status_e st);
    list_result_t r;
    r.status     = st;
    r.item_value = '0;
    r.last_item  = 1'b1;
    pending_results.push_back(r);
  endtask

  // Apply one transaction to the shadow list and queue its results
  task automatic apply_list_op(list_op_t t);
    logic [VALUE_WIDTH-1:0] tgt;
    logic [VALUE_WIDTH-1:0] val;
    int                     pos;
    int                     n;
    list_result_t           r;
    tgt = to_stored(t.target);
    val = to_stored(t.value);
    case (t.op)
      olv_pkg::OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          push_single(olv_pkg::ST_FULL);
        end else begin
          list_entries[list_len] = val;
          list_len++;
          push_single(olv_pkg::ST_OK);
        end
      end
      olv_pkg::OP_INSERT: begin
        pos = find_first(tgt);
        if (list_len == 0) begin
          push_single(olv_pkg::ST_EMPTY);
        end else if (pos >= list_len) begin
          push_single(olv_pkg::ST_NOTFOUND);
        end else if (list_len >= CAPACITY) begin
          push_single(olv_pkg::ST_FULL);
        end else begin
          for (int i = list_len; i > pos; i--) list_entries[i] = list_entries[i-1];
          list_entries[pos] = val;
          list_len++;
          push_single(olv_pkg::ST_OK);
        end
      end
      olv_pkg::OP_DELETE: begin
        pos = find_first(val);
        if (list_len == 0) begin
          push_single(olv_pkg::ST_EMPTY);
        end else if (pos >= list_len) begin
          push_single(olv_pkg::ST_NOTFOUND);
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
          list_len--;
          push_single(olv_pkg::ST_OK);
        end
      end
      default: begin
        if (list_len == 0) begin
          push_single(olv_pkg::ST_EMPTY);
        end else begin
          n = (list_len > olv_pkg::MAX_RESULTS) ? olv_pkg::MAX_RESULTS : list_len;
          for (int i = 0; i < n; i++) begin
            r.status     = olv_pkg::ST_OK;
            r.item_value = to_emitted(list_entries[i]);
            r.last_item  = (i + 1 == n);
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic add_op(olv_pkg::op_e op, logic signed [31:0] tgt,
                        logic signed [31:0] val, bit drain);
    list_op_t t;
    t.op     = op;
    t.target = tgt;
    t.value  = val;
    t.drain  = drain;
    op_queue.push_back(t);
  endtask

  // Small pool so that inserts and deletes find their keys, plus full noise
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 8))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return 32'sd1;
      5: return 32'sd2;
      6: return 32'sh5555_5555;
      7: return 32'shaaaa_aaaa;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  // Driver: predict on every accepted transaction, then launch the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) apply_list_op(in_flight);
      quiet_tail <= (op_queue.size() < QUIET_ITEMS);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (op_queue.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (op_queue[0].drain && pending_results.size() != 0) begin
          // hold off until every outstanding result has drained
          in_valid_i <= 1'b0;
        end else begin
          in_flight = op_queue.pop_front();
          opcode_i   <= in_flight.op;
          target_i   <= in_flight.target;
          value_i    <= in_flight.value;
          in_valid_i <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 17);
        end
      end
    end
  end

  // Monitor: check each output transaction against the oldest expectation
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d value %0d last %0b",
                                    status_o, item_value_o, last_item_o));
        end else begin
          exp_r = pending_results.pop_front();
          if (status_o !== exp_r.status || item_value_o !== exp_r.item_value ||
              last_item_o !== exp_r.last_item) begin
            report_mismatch($sformatf(
              "result mismatch: status %0d/%0d value %0d/%0d last %0b/%0b (exp/act)",
              exp_r.status, status_o, exp_r.item_value, item_value_o,
              exp_r.last_item, last_item_o));
          end
        end
      end
      // drop ready in random bursts outside the tail of the run
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    bit timed_out;
    int r;
    bit grow;
    idle_cycles = 0;
    timed_out   = 1'b0;

    // Directed: empty-list cases, extremes, misses, hits, full list
    add_op(olv_pkg::OP_DUMP,   32'sd0, 32'sd0, 1'b0);
    add_op(olv_pkg::OP_DELETE, 32'sd0, 32'sd5, 1'b0);
    add_op(olv_pkg::OP_INSERT, 32'sd5, 32'sd6, 1'b0);
    add_op(olv_pkg::OP_APPEND, 32'sd0, 32'sh8000_0000, 1'b0);
    add_op(olv_pkg::OP_APPEND, 32'sd0, 32'sh7fff_ffff, 1'b0);
    add_op(olv_pkg::OP_APPEND, 32'sd0, -32'sd1, 1'b0);
    add_op(olv_pkg::OP_DUMP,   32'sh7fff_ffff, -32'sd1, 1'b0);
    add_op(olv_pkg::OP_INSERT, 32'sh7fff_ffff, 32'sd42, 1'b0);
    add_op(olv_pkg::OP_INSERT, 32'sd123, 32'sd7, 1'b0);
    add_op(olv_pkg::OP_DELETE, 32'sd0, 32'sd77, 1'b0);
    add_op(olv_pkg::OP_DELETE, 32'sd0, 32'sh8000_0000, 1'b0);
    for (int i = 0; i < 12; i++) add_op(olv_pkg::OP_APPEND, $urandom, pick_value(), 1'b0);
    add_op(olv_pkg::OP_APPEND, 32'sd0, 32'sd9, 1'b0);
    add_op(olv_pkg::OP_INSERT, 32'sd42, 32'sd9, 1'b0);
    add_op(olv_pkg::OP_DUMP,   $urandom, $urandom, 1'b0);

    // Random: alternate growing and shrinking phases over a value pool
    for (int i = 0; i < RAND_ITEMS; i++) begin
      grow = ((i / 30) % 2 == 0);
      r = $urandom_range(0, 99);
      if (grow ? (r < 45) : (r < 15)) begin
        add_op(olv_pkg::OP_APPEND, $urandom, pick_value(),
               i == 0 || i == RAND_ITEMS / 2);
      end else if (grow ? (r < 70) : (r < 25)) begin
        add_op(olv_pkg::OP_INSERT, pick_value(), pick_value(),
               i == 0 || i == RAND_ITEMS / 2);
      end else if (grow ? (r < 85) : (r < 80)) begin
        add_op(olv_pkg::OP_DELETE, $urandom, pick_value(),
               i == 0 || i == RAND_ITEMS / 2);
      end else begin
        add_op(olv_pkg::OP_DUMP, $urandom, $urandom, i == 0 || i == RAND_ITEMS / 2);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Watch for progress until stimulus and results are exhausted
    while (!timed_out && (op_queue.size() != 0 || in_valid_i ||
                          pending_results.size() != 0)) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
    end

    if (timed_out) begin
      $display("Mismatches found");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk_i);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule
